// File: rtl/lvcf_pkg.sv
// Shared types, constants and helper functions of the landmark view cone filter.
package lvcf_pkg;

    // Cosine and sine of the 10 degree pitch, Q1.30.
    localparam logic signed [31:0] PITCH_COS = 32'sd1057429273;
    localparam logic signed [31:0] PITCH_SIN = 32'sd186453311;
    // Quaternion one in Q1.14 and rotation one in the Q.27 matrix format.
    localparam logic signed [15:0] Q_ONE = 16'sd16384;
    localparam logic signed [31:0] R_ONE = 32'sd134217728;
    localparam logic [30:0] RANGE_RESET = 31'd85197;

    typedef enum logic [2:0] {
        CFG_POSE_X   = 3'd0,
        CFG_POSE_Y   = 3'd1,
        CFG_POSE_Z   = 3'd2,
        CFG_ORIENT_W = 3'd3,
        CFG_ORIENT_X = 3'd4,
        CFG_ORIENT_Y = 3'd5,
        CFG_ORIENT_Z = 3'd6,
        CFG_RANGE    = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic signed [31:0] raw_x;
        logic signed [31:0] raw_y;
        logic signed [31:0] raw_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_z;
        logic signed [31:0] map_x;
        logic signed [31:0] map_y;
        logic signed [31:0] map_z;
    } t_out_item;

    // Pose rotation matrix in Q.27, plus the yaw direction used by the heading test.
    typedef struct packed {
        logic signed [31:0] r00;
        logic signed [31:0] r01;
        logic signed [31:0] r02;
        logic signed [31:0] r10;
        logic signed [31:0] r11;
        logic signed [31:0] r12;
        logic signed [31:0] r20;
        logic signed [31:0] r21;
        logic signed [31:0] r22;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
    } t_rot;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] res;
        if (v > 66'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [15:0] clampq(input logic signed [15:0] v);
        logic signed [15:0] res;
        if (v > Q_ONE) begin
            res = Q_ONE;
        end else if (v < -Q_ONE) begin
            res = -Q_ONE;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// File: rtl/lvcf_front.sv
// Pitch correction of the raw point and its offset from the pose position.
module lvcf_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  lvcf_pkg::t_in_item     i_item,
    input  logic signed [31:0]     i_pose_x,
    input  logic signed [31:0]     i_pose_y,
    input  logic signed [31:0]     i_pose_z,
    output logic                   o_valid,
    output logic signed [31:0]     o_mx,
    output logic signed [31:0]     o_my,
    output logic signed [31:0]     o_mz,
    output logic signed [32:0]     o_dx,
    output logic signed [32:0]     o_dy,
    output logic signed [32:0]     o_dz
);

    logic               r_s1_v;
    logic signed [63:0] r_s1_cx, r_s1_sz, r_s1_sx, r_s1_cz;
    logic signed [31:0] r_s1_y;
    logic signed [63:0] n_sum_x, n_sum_z;
    logic signed [31:0] n_mx, n_mz;
    logic               r_s2_v;
    logic signed [31:0] r_s2_mx, r_s2_my, r_s2_mz;
    logic signed [32:0] r_s2_dx, r_s2_dy, r_s2_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_cx <= lvcf_pkg::PITCH_COS * $signed(i_item.raw_x);
        r_s1_sz <= lvcf_pkg::PITCH_SIN * $signed(i_item.raw_z);
        r_s1_sx <= lvcf_pkg::PITCH_SIN * $signed(i_item.raw_x);
        r_s1_cz <= lvcf_pkg::PITCH_COS * $signed(i_item.raw_z);
        r_s1_y  <= i_item.raw_y;
    end

    // Round half up: add half an output unit, then shift arithmetically.
    always_comb begin
        n_sum_x = r_s1_cx + r_s1_sz + 64'sd536870912;
        n_sum_z = r_s1_cz - r_s1_sx + 64'sd536870912;
        n_mx = lvcf_pkg::sat32(66'(n_sum_x >>> 30));
        n_mz = lvcf_pkg::sat32(66'(n_sum_z >>> 30));
    end

    always_ff @(posedge i_clk) begin
        r_s2_mx <= n_mx;
        r_s2_my <= r_s1_y;
        r_s2_mz <= n_mz;
        r_s2_dx <= 33'(n_mx) - 33'(i_pose_x);
        r_s2_dy <= 33'(r_s1_y) - 33'(i_pose_y);
        r_s2_dz <= 33'(n_mz) - 33'(i_pose_z);
    end

    assign o_valid = r_s2_v;
    assign o_mx = r_s2_mx;
    assign o_my = r_s2_my;
    assign o_mz = r_s2_mz;
    assign o_dx = r_s2_dx;
    assign o_dy = r_s2_dy;
    assign o_dz = r_s2_dz;

endmodule

// File: rtl/lvcf_rotm.sv
// Pose rotation matrix and three times the squared yaw direction norm, built from the configured quaternion.
module lvcf_rotm (
    input  logic                i_clk,
    input  logic signed [15:0]  i_qw,
    input  logic signed [15:0]  i_qx,
    input  logic signed [15:0]  i_qy,
    input  logic signed [15:0]  i_qz,
    output lvcf_pkg::t_rot      o_rot,
    output logic [60:0]         o_uu3
);

    logic signed [15:0] qw, qx, qy, qz;
    logic signed [31:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    lvcf_pkg::t_rot     n_rot;
    logic [63:0]        r_uxsq, r_uysq;
    logic [60:0]        r_uu3;
    logic [63:0]        n_uxsq, n_uysq;
    logic [61:0]        n_uu;

    always_comb begin
        qw = lvcf_pkg::clampq(i_qw);
        qx = lvcf_pkg::clampq(i_qx);
        qy = lvcf_pkg::clampq(i_qy);
        qz = lvcf_pkg::clampq(i_qz);
    end

    always_ff @(posedge i_clk) begin
        r_xx <= qx * qx;
        r_yy <= qy * qy;
        r_zz <= qz * qz;
        r_xy <= qx * qy;
        r_xz <= qx * qz;
        r_yz <= qy * qz;
        r_wx <= qw * qx;
        r_wy <= qw * qy;
        r_wz <= qw * qz;
    end

    always_comb begin
        n_rot.r00 = lvcf_pkg::R_ONE - (r_yy + r_zz);
        n_rot.r01 = r_xy - r_wz;
        n_rot.r02 = r_xz + r_wy;
        n_rot.r10 = r_xy + r_wz;
        n_rot.r11 = lvcf_pkg::R_ONE - (r_xx + r_zz);
        n_rot.r12 = r_yz - r_wx;
        n_rot.r20 = r_xz - r_wy;
        n_rot.r21 = r_yz + r_wx;
        n_rot.r22 = lvcf_pkg::R_ONE - (r_xx + r_yy);
        // A degenerate yaw direction counts as yaw zero.
        if (n_rot.r00 == 32'sd0 && n_rot.r10 == 32'sd0) begin
            n_rot.ux = 32'sd1;
        end else begin
            n_rot.ux = n_rot.r00;
        end
        n_rot.uy = n_rot.r10;
    end

    always_comb begin
        n_uxsq = 64'($signed(n_rot.ux) * $signed(n_rot.ux));
        n_uysq = 64'($signed(n_rot.uy) * $signed(n_rot.uy));
        n_uu   = 62'(r_uxsq) + 62'(r_uysq);
    end

    always_ff @(posedge i_clk) begin
        r_uxsq <= n_uxsq;
        r_uysq <= n_uysq;
        r_uu3  <= 61'({n_uu, 1'b0}) + 61'(n_uu);
    end

    assign o_rot = n_rot;
    assign o_uu3 = r_uu3;

endmodule

// File: rtl/lvcf_gate.sv
// Range and heading tests, pose frame rotation and the result register.
module lvcf_gate (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic signed [31:0]     i_mx,
    input  logic signed [31:0]     i_my,
    input  logic signed [31:0]     i_mz,
    input  logic signed [32:0]     i_dx,
    input  logic signed [32:0]     i_dy,
    input  logic signed [32:0]     i_dz,
    input  logic [30:0]            i_range,
    input  lvcf_pkg::t_rot         i_rot,
    input  logic [60:0]            i_uu3,
    output logic                   o_valid,
    output lvcf_pkg::t_out_item    o_result
);

    // Stage 3: squares and products.
    logic               r_s3_v, r_s3_rfail, r_s3_zero;
    logic [63:0]        r_s3_dxsq, r_s3_dysq;
    logic [61:0]        r_s3_rsq;
    logic signed [64:0] r_s3_pux, r_s3_puy;
    logic signed [65:0] r_s3_c [9];
    logic signed [31:0] r_s3_mx, r_s3_my, r_s3_mz;
    logic signed [32:0] n_hx;
    logic               n_rfail, n_zero;

    // Stage 4: sums and cam rounding.
    logic               r_s4_v, r_s4_fail;
    logic [61:0]        r_s4_dot;
    logic [63:0]        r_s4_hd;
    logic signed [31:0] r_s4_cam [3];
    logic signed [31:0] r_s4_mx, r_s4_my, r_s4_mz;
    logic [63:0]        n_dd;
    logic signed [65:0] n_dot;
    logic signed [65:0] n_cs [3];

    // Stage 5: partial products of the heading comparison.
    logic               r_s5_v, r_s5_fail;
    logic [63:0]        r_s5_ll, r_s5_p00, r_s5_p10;
    logic [61:0]        r_s5_lh;
    logic [59:0]        r_s5_hh;
    logic [60:0]        r_s5_p01, r_s5_p11;
    logic signed [31:0] r_s5_cam [3];
    logic signed [31:0] r_s5_mx, r_s5_my, r_s5_mz;

    // Output register.
    logic               r_ov;
    lvcf_pkg::t_out_item r_res;
    logic [127:0]       n_lhs, n_rhs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_s3_v <= i_valid;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_ov <= r_s5_v && !r_s5_fail && (n_lhs >= n_rhs);
        end
    end

    always_comb begin
        n_rfail = (i_dx > 33'($signed({1'b0, i_range}))) ||
                  (i_dx < -33'($signed({1'b0, i_range}))) ||
                  (i_dy > 33'($signed({1'b0, i_range}))) ||
                  (i_dy < -33'($signed({1'b0, i_range})));
        n_zero = (i_dx == 33'sd0) && (i_dy == 33'sd0);
        // A point at the pose position counts as heading zero.
        n_hx = n_zero ? 33'sd1 : i_dx;
    end

    always_ff @(posedge i_clk) begin
        r_s3_rfail <= n_rfail;
        r_s3_zero  <= n_zero;
        r_s3_dxsq  <= 64'(i_dx * i_dx);
        r_s3_dysq  <= 64'(i_dy * i_dy);
        r_s3_rsq   <= i_range * i_range;
        r_s3_pux   <= n_hx * $signed(i_rot.ux);
        r_s3_puy   <= i_dy * $signed(i_rot.uy);
        r_s3_c[0]  <= $signed(i_rot.r00) * i_dx;
        r_s3_c[1]  <= $signed(i_rot.r10) * i_dy;
        r_s3_c[2]  <= $signed(i_rot.r20) * i_dz;
        r_s3_c[3]  <= $signed(i_rot.r01) * i_dx;
        r_s3_c[4]  <= $signed(i_rot.r11) * i_dy;
        r_s3_c[5]  <= $signed(i_rot.r21) * i_dz;
        r_s3_c[6]  <= $signed(i_rot.r02) * i_dx;
        r_s3_c[7]  <= $signed(i_rot.r12) * i_dy;
        r_s3_c[8]  <= $signed(i_rot.r22) * i_dz;
        r_s3_mx    <= i_mx;
        r_s3_my    <= i_my;
        r_s3_mz    <= i_mz;
    end

    always_comb begin
        n_dd  = r_s3_dxsq + r_s3_dysq;
        n_dot = 66'(r_s3_pux) + 66'(r_s3_puy);
        for (int i = 0; i < 3; i++) begin
            n_cs[i] = r_s3_c[3*i] + r_s3_c[3*i+1] + r_s3_c[3*i+2] + 66'sd67108864;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_fail <= r_s3_rfail || (n_dd > 64'(r_s3_rsq)) || (n_dot < 66'sd0);
        r_s4_dot  <= n_dot[61:0];
        r_s4_hd   <= r_s3_zero ? 64'd1 : n_dd;
        for (int i = 0; i < 3; i++) begin
            r_s4_cam[i] <= lvcf_pkg::sat32(n_cs[i] >>> 27);
        end
        r_s4_mx <= r_s3_mx;
        r_s4_my <= r_s3_my;
        r_s4_mz <= r_s3_mz;
    end

    always_ff @(posedge i_clk) begin
        r_s5_fail <= r_s4_fail;
        r_s5_ll   <= r_s4_dot[31:0] * r_s4_dot[31:0];
        r_s5_lh   <= r_s4_dot[31:0] * r_s4_dot[61:32];
        r_s5_hh   <= r_s4_dot[61:32] * r_s4_dot[61:32];
        r_s5_p00  <= r_s4_hd[31:0] * i_uu3[31:0];
        r_s5_p01  <= r_s4_hd[31:0] * i_uu3[60:32];
        r_s5_p10  <= r_s4_hd[63:32] * i_uu3[31:0];
        r_s5_p11  <= r_s4_hd[63:32] * i_uu3[60:32];
        r_s5_cam  <= r_s4_cam;
        r_s5_mx   <= r_s4_mx;
        r_s5_my   <= r_s4_my;
        r_s5_mz   <= r_s4_mz;
    end

    // Keep when four times the squared dot product reaches three |d|^2 |u|^2.
    always_comb begin
        n_lhs = 128'({r_s5_hh, 66'b0}) + 128'({r_s5_lh, 35'b0}) +
                128'({r_s5_ll, 2'b0});
        n_rhs = 128'({r_s5_p11, 64'b0}) +
                128'({(65'(r_s5_p01) + 65'(r_s5_p10)), 32'b0}) +
                128'(r_s5_p00);
    end

    always_ff @(posedge i_clk) begin
        r_res.cam_x <= r_s5_cam[0];
        r_res.cam_y <= r_s5_cam[1];
        r_res.cam_z <= r_s5_cam[2];
        r_res.map_x <= r_s5_mx;
        r_res.map_y <= r_s5_my;
        r_res.map_z <= r_s5_mz;
    end

    assign o_valid  = r_ov;
    assign o_result = r_res;

    a_out_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> $past(r_s5_v))
        else $error("result strobe without an item in the last stage");

    a_range_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_v && r_s3_rfail |-> ##3 !r_ov)
        else $error("point outside the range box produced a result");

    a_fail_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_v && r_s4_fail |=> r_s5_fail)
        else $error("drop decision lost between stages");

endmodule

// File: rtl/landmark_view_cone_filter_top.sv
// Top level of the landmark view cone filter: configuration registers and pipeline.
// One map point enters per cycle whenever start is high; busy is always low because
// every stage advances each cycle. A kept point appears on o_result with o_valid high
// for one cycle after passing two stages for the pitch multiply and pose offset, the
// first of them registered at the accepting edge, then four stages for the squares, the
// heading products, their wide partial products and the final comparison. A dropped
// point gives no strobe.
// The receiver cannot stall the block, so results must be taken when shown.
// Configuration takes effect for points started after the write.
module landmark_view_cone_filter_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  lvcf_pkg::t_in_item     i_item,
    output logic                   o_valid,
    output lvcf_pkg::t_out_item    o_result,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_index,
    input  logic [31:0]            i_cfg_data
);

    logic signed [31:0] r_pose_x, r_pose_y, r_pose_z;
    logic signed [15:0] r_qw, r_qx, r_qy, r_qz;
    logic [30:0]        r_range;

    logic               f_valid;
    logic signed [31:0] f_mx, f_my, f_mz;
    logic signed [32:0] f_dx, f_dy, f_dz;
    lvcf_pkg::t_rot     rot;
    logic [60:0]        uu3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose_x <= 32'sd0;
            r_pose_y <= 32'sd0;
            r_pose_z <= 32'sd0;
            r_qw     <= lvcf_pkg::Q_ONE;
            r_qx     <= 16'sd0;
            r_qy     <= 16'sd0;
            r_qz     <= 16'sd0;
            r_range  <= lvcf_pkg::RANGE_RESET;
        end else if (i_cfg_we) begin
            unique case (lvcf_pkg::t_cfg_index'(i_cfg_index))
                lvcf_pkg::CFG_POSE_X:   r_pose_x <= i_cfg_data;
                lvcf_pkg::CFG_POSE_Y:   r_pose_y <= i_cfg_data;
                lvcf_pkg::CFG_POSE_Z:   r_pose_z <= i_cfg_data;
                lvcf_pkg::CFG_ORIENT_W: r_qw <= i_cfg_data[15:0];
                lvcf_pkg::CFG_ORIENT_X: r_qx <= i_cfg_data[15:0];
                lvcf_pkg::CFG_ORIENT_Y: r_qy <= i_cfg_data[15:0];
                lvcf_pkg::CFG_ORIENT_Z: r_qz <= i_cfg_data[15:0];
                lvcf_pkg::CFG_RANGE:    r_range <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    lvcf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start && !busy),
        .i_item   (i_item),
        .i_pose_x (r_pose_x),
        .i_pose_y (r_pose_y),
        .i_pose_z (r_pose_z),
        .o_valid  (f_valid),
        .o_mx     (f_mx),
        .o_my     (f_my),
        .o_mz     (f_mz),
        .o_dx     (f_dx),
        .o_dy     (f_dy),
        .o_dz     (f_dz)
    );

    lvcf_rotm u_rotm (
        .i_clk (i_clk),
        .i_qw  (r_qw),
        .i_qx  (r_qx),
        .i_qy  (r_qy),
        .i_qz  (r_qz),
        .o_rot (rot),
        .o_uu3 (uu3)
    );

    lvcf_gate u_gate (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (f_valid),
        .i_mx     (f_mx),
        .i_my     (f_my),
        .i_mz     (f_mz),
        .i_dx     (f_dx),
        .i_dy     (f_dy),
        .i_dz     (f_dz),
        .i_range  (r_range),
        .i_rot    (rot),
        .i_uu3    (uu3),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
